// ----- src/tct_pkg.sv -----
// Shared types and constants for the text console teletype.
// Holds operation codes, the front-to-back command record and character constants.
// No dependencies.
package tct_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS = 25;
	localparam int MAX_LIN_W = 13;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] RESET_ATTR = 8'h07;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_MOVE  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CMD_PUT,
		CMD_NEWLINE,
		CMD_MOVE,
		CMD_BAD_MOVE,
		CMD_CLEAR,
		CMD_READ,
		CMD_READ_NONE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [7:0]             ch;
		logic [7:0]             attr;
		logic [6:0]             col;
		logic [5:0]             row;
		logic [MAX_LIN_W-1:0]   lin;
		logic [10:0]            index;
	} cmd_t;

endpackage

// ----- src/tct_if.sv -----
// Request and response channel interfaces of the text console teletype.
// Valid/ready handshake with the payload fields; no package dependency.
interface tct_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] char_code;
	logic [6:0] column;
	logic [5:0] row;
	logic [7:0] fill_attribute;
	logic [10:0] cell_index;

	modport source (output valid, operation, char_code, column, row, fill_attribute,
		cell_index, input ready);
	modport sink (input valid, operation, char_code, column, row, fill_attribute,
		cell_index, output ready);
endinterface

interface tct_out_if;
	logic        valid;
	logic        ready;
	logic        bad_position;
	logic [10:0] cursor_position;
	logic [7:0]  cell_char;
	logic [7:0]  cell_attr;

	modport source (output valid, bad_position, cursor_position, cell_char, cell_attr,
		input ready);
	modport sink (input valid, bad_position, cursor_position, cell_char, cell_attr,
		output ready);
endinterface

// ----- src/tct_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tct_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/tct_front.sv -----
// Front end: accepts request transactions, decodes them into commands.
// Depends on tct_pkg and tct_in_if.
module tct_front #(
	parameter int SCREEN_COLUMNS = tct_pkg::DEF_COLUMNS,
	parameter int SCREEN_ROWS = tct_pkg::DEF_ROWS
) (
	tct_in_if.sink        req,
	input  logic          q_full,
	output logic          push,
	output tct_pkg::cmd_t cmd
);

	localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int LW = tct_pkg::MAX_LIN_W;

	logic          col_bad;
	logic          row_bad;
	logic [6:0]    col0;
	logic [5:0]    row0;
	tct_pkg::op_t  op;

	assign req.ready = !q_full;
	assign push = req.valid && !q_full;

	assign op = tct_pkg::op_t'(req.operation);
	assign col0 = req.column - 7'd1;
	assign row0 = req.row - 6'd1;
	assign col_bad = (req.column == 7'd0) || (32'(req.column) > SCREEN_COLUMNS);
	assign row_bad = (req.row == 6'd0) || (32'(req.row) > SCREEN_ROWS);

	always_comb begin
		cmd.ch = req.char_code;
		cmd.attr = req.fill_attribute;
		cmd.col = col0;
		cmd.row = row0;
		cmd.lin = LW'(row0) * LW'(SCREEN_COLUMNS) + LW'(col0);
		cmd.index = req.cell_index;
		unique case (op)
			tct_pkg::OP_PUT: begin
				cmd.kind = (req.char_code == tct_pkg::CHAR_NEWLINE) ?
					tct_pkg::CMD_NEWLINE : tct_pkg::CMD_PUT;
			end
			tct_pkg::OP_MOVE: begin
				cmd.kind = (col_bad || row_bad) ? tct_pkg::CMD_BAD_MOVE : tct_pkg::CMD_MOVE;
			end
			tct_pkg::OP_CLEAR: begin
				cmd.kind = tct_pkg::CMD_CLEAR;
			end
			default: begin
				cmd.kind = (32'(req.cell_index) < CELLS) ?
					tct_pkg::CMD_READ : tct_pkg::CMD_READ_NONE;
			end
		endcase
	end

endmodule

// ----- src/tct_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on tct_pkg.
module tct_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tct_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output tct_pkg::cmd_t head
);

	localparam int DEPTH = tct_pkg::QUEUE_DEPTH;
	localparam int PW = $clog2(DEPTH);

	tct_pkg::cmd_t  entry_q [DEPTH];
	logic [PW-1:0]  wptr_q;
	logic [PW-1:0]  rptr_q;
	logic [PW:0]    count_q;

	assign full = (count_q == (PW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign head = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/tct_back.sv -----
// Back end: owns the cursor and the screen store, runs commands, drives responses.
// Depends on tct_pkg, tct_out_if and tct_ram.
module tct_back #(
	parameter int SCREEN_COLUMNS = tct_pkg::DEF_COLUMNS,
	parameter int SCREEN_ROWS = tct_pkg::DEF_ROWS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    text_attribute,
	input  tct_pkg::cmd_t head,
	input  logic          empty,
	output logic          pop,
	tct_out_if.source     rsp
);

	localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int CW = $clog2(CELLS);
	localparam int CNTW = $clog2(CELLS + 1);
	localparam int COLW = $clog2(SCREEN_COLUMNS);
	localparam int ROWW = $clog2(SCREEN_ROWS);

	localparam logic [CW-1:0] LAST_ROW_START = CW'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);
	localparam logic [CW-1:0] COLS_W = CW'(SCREEN_COLUMNS);
	localparam logic [CNTW-1:0] CELLS_N = CNTW'(CELLS);
	localparam logic [CNTW-1:0] COPY_N = CNTW'(CELLS - SCREEN_COLUMNS);
	localparam logic [COLW-1:0] COL_LAST = COLW'(SCREEN_COLUMNS - 1);
	localparam logic [ROWW-1:0] ROW_LAST = ROWW'(SCREEN_ROWS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SCROLL,
		S_CLEAR
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cursor_q;
	logic [COLW-1:0] ccol_q;
	logic [ROWW-1:0] crow_q;
	logic [CNTW-1:0] cnt_q;
	logic [7:0]      clr_attr_q;
	logic            out_valid_q;
	logic            bad_q;
	logic [7:0]      rc_q;
	logic [7:0]      ra_q;

	logic            ram_we;
	logic [CW-1:0]   ram_waddr;
	logic [15:0]     ram_wdata;
	logic [CW-1:0]   ram_raddr;
	logic [15:0]     ram_rdata;

	tct_ram #(
		.WIDTH (16),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign pop = (state_q == S_IDLE) && !empty && (!out_valid_q || rsp.ready);

	assign rsp.valid = out_valid_q;
	assign rsp.bad_position = bad_q;
	assign rsp.cursor_position = 11'(cursor_q);
	assign rsp.cell_char = rc_q;
	assign rsp.cell_attr = ra_q;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = cursor_q;
		ram_wdata = {text_attribute, head.ch};
		ram_raddr = CW'(head.index);
		unique case (state_q)
			S_IDLE: begin
				ram_we = pop && (head.kind == tct_pkg::CMD_PUT);
			end
			S_SCROLL: begin
				// read one row ahead, write back the cell fetched last cycle, or a blank on the last row
				ram_raddr = CW'(cnt_q) + COLS_W;
				ram_we = (cnt_q != '0);
				ram_waddr = CW'(cnt_q - 1'b1);
				ram_wdata = (cnt_q <= COPY_N) ? ram_rdata : {text_attribute, tct_pkg::CHAR_SPACE};
			end
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = CW'(cnt_q);
				ram_wdata = {clr_attr_q, tct_pkg::CHAR_SPACE};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cursor_q <= '0;
			ccol_q <= '0;
			crow_q <= '0;
			cnt_q <= '0;
			clr_attr_q <= '0;
			out_valid_q <= 1'b0;
			bad_q <= 1'b0;
			rc_q <= '0;
			ra_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						bad_q <= (head.kind == tct_pkg::CMD_BAD_MOVE);
						rc_q <= '0;
						ra_q <= '0;
						unique case (head.kind)
							tct_pkg::CMD_PUT: begin
								if (ccol_q == COL_LAST && crow_q == ROW_LAST) begin
									state_q <= S_SCROLL;
									cnt_q <= '0;
									out_valid_q <= 1'b0;
								end else begin
									out_valid_q <= 1'b1;
									cursor_q <= cursor_q + 1'b1;
									if (ccol_q == COL_LAST) begin
										ccol_q <= '0;
										crow_q <= crow_q + 1'b1;
									end else begin
										ccol_q <= ccol_q + 1'b1;
									end
								end
							end
							tct_pkg::CMD_NEWLINE: begin
								if (crow_q == ROW_LAST) begin
									state_q <= S_SCROLL;
									cnt_q <= '0;
									out_valid_q <= 1'b0;
								end else begin
									out_valid_q <= 1'b1;
									cursor_q <= cursor_q + COLS_W - CW'(ccol_q);
									ccol_q <= '0;
									crow_q <= crow_q + 1'b1;
								end
							end
							tct_pkg::CMD_MOVE: begin
								out_valid_q <= 1'b1;
								cursor_q <= CW'(head.lin);
								ccol_q <= COLW'(head.col);
								crow_q <= ROWW'(head.row);
							end
							tct_pkg::CMD_BAD_MOVE: begin
								out_valid_q <= 1'b1;
							end
							tct_pkg::CMD_CLEAR: begin
								state_q <= S_CLEAR;
								cnt_q <= '0;
								clr_attr_q <= head.attr;
								out_valid_q <= 1'b0;
							end
							tct_pkg::CMD_READ: begin
								state_q <= S_READ;
								out_valid_q <= 1'b0;
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end else if (rsp.ready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_READ: begin
					rc_q <= ram_rdata[7:0];
					ra_q <= ram_rdata[15:8];
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCROLL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CELLS_N) begin
						state_q <= S_IDLE;
						cursor_q <= LAST_ROW_START;
						ccol_q <= '0;
						crow_q <= ROW_LAST;
						out_valid_q <= 1'b1;
					end
				end
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CELLS_N - 1'b1) begin
						state_q <= S_IDLE;
						cursor_q <= '0;
						ccol_q <= '0;
						crow_q <= '0;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cursor_in_screen: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cursor_q) < CELLS)
		else $error("cursor beyond screen");

	a_cursor_matches_rowcol: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cursor_q) == 32'(crow_q) * SCREEN_COLUMNS + 32'(ccol_q))
		else $error("linear cursor out of step with row and column");

	a_no_result_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCROLL || state_q == S_CLEAR) |-> !out_valid_q)
		else $error("response shown while store sweep in progress");

	a_cursor_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> $stable(cursor_q))
		else $error("cursor moved under a stalled response");

	a_read_follows_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> $past(pop))
		else $error("read state entered without a command");

endmodule

// ----- src/text_console_teletype.sv -----
// Text console teletype: character-cell screen store with cursor, scroll and clear.
// Request channel req (tct_in_if.sink) carries operation, char_code, column, row,
// fill_attribute and cell_index; every request yields one response on rsp
// (tct_out_if.source) with bad_position, cursor_position, cell_char and cell_attr.
// cfg_we/cfg_wdata write the text attribute used for printed characters and scroll
// blanking; write it only while no transaction is in flight.
// Requests are decoded into a two-entry command queue; the back end runs one command
// at a time against a single-port-write, registered-read screen RAM.
// A response is registered once the accepted request has passed the command queue
// and the back end; a cell read also passes the S_READ state for the registered RAM
// read. A clear and a scroll hold the back end while the one RAM write port walks the
// whole store; requests queue up to two deep meanwhile.
// Throughput: one put char, move or out-of-range read per cycle while rsp is ready;
// a cell read holds the back end in S_READ for the registered RAM read.
// Reset clears the cursor to the home position, sets the text attribute to 7 and
// empties the queue; the screen store holds nothing valid until written or cleared.
// While rsp stalls, the response holds and the back end takes no new command.
// Depends on tct_pkg, tct_if, tct_ram, tct_front, tct_queue and tct_back.
module text_console_teletype #(
	parameter int SCREEN_COLUMNS = tct_pkg::DEF_COLUMNS,
	parameter int SCREEN_ROWS = tct_pkg::DEF_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	tct_in_if.sink     req,
	tct_out_if.source  rsp
);

	logic [7:0]    text_attribute_q;
	logic          q_full;
	logic          q_empty;
	logic          push;
	logic          pop;
	tct_pkg::cmd_t cmd;
	tct_pkg::cmd_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attribute_q <= tct_pkg::RESET_ATTR;
		end else if (cfg_we) begin
			text_attribute_q <= cfg_wdata;
		end
	end

	tct_front #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS)
	) u_front (
		.req    (req),
		.q_full (q_full),
		.push   (push),
		.cmd    (cmd)
	);

	tct_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd),
		.full   (q_full),
		.pop    (pop),
		.empty  (q_empty),
		.head   (head)
	);

	tct_back #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.text_attribute (text_attribute_q),
		.head           (head),
		.empty          (q_empty),
		.pop            (pop),
		.rsp            (rsp)
	);

endmodule
